FILE: rtl/lrsf_pkg.sv
package lrsf_pkg;

   // Interpolation table: knee angles 0,16,33,49,65,82,98 deg; heights in 1/256 mm.
   localparam int TABLE_POINTS = 7;
   localparam int MAX_POINTS   = 16;
   localparam int LAST_POINT   = (TABLE_POINTS < 2) ? 1 :
                                 (TABLE_POINTS > MAX_POINTS) ? MAX_POINTS - 1 :
                                 TABLE_POINTS - 1;

   localparam int H_W   = 16;           // leg height
   localparam int CNT_W = 9;            // hip / knee counts
   localparam int Q_W   = 6;            // interpolation step, table deltas stay below 64
   localparam int P_W   = H_W + Q_W;    // product / remainder
   localparam int POS_W = 10;           // servo position
   localparam int SUM_W = 12;           // signed position sum before clamping
   localparam int BYTE_W = 8;
   localparam int SPEED_W = 10;
   localparam int CSR_IDX_W = 2;

   localparam logic [H_W-1:0] HEIGHT_TAB [MAX_POINTS] = '{
      16'd57370, 16'd56811, 16'd55007, 16'd52205, 16'd48386, 16'd43299, 16'd37640,
      16'd37640, 16'd37640, 16'd37640, 16'd37640, 16'd37640, 16'd37640, 16'd37640,
      16'd37640, 16'd37640};
   localparam logic [CNT_W-1:0] HIP_TAB [MAX_POINTS] = '{
      9'd0, 9'd34, 9'd68, 9'd102, 9'd136, 9'd170, 9'd205,
      9'd205, 9'd205, 9'd205, 9'd205, 9'd205, 9'd205, 9'd205, 9'd205, 9'd205};
   localparam logic [CNT_W-1:0] KNEE_TAB [MAX_POINTS] = '{
      9'd0, 9'd53, 9'd111, 9'd167, 9'd223, 9'd280, 9'd334,
      9'd334, 9'd334, 9'd334, 9'd334, 9'd334, 9'd334, 9'd334, 9'd334, 9'd334};

   // Servo position offsets
   localparam int POS_MAX    = 1023;
   localparam int POS_MID    = 512;
   localparam int OFS_HIP_R  = 60;
   localparam int OFS_KNEE_L = -28;
   localparam int OFS_KNEE_R = 30;

   // Frame constants
   localparam logic [7:0] HDR_BYTE    = 8'hFF;
   localparam logic [7:0] BCAST_ID    = 8'hFE;
   localparam logic [7:0] SYNC_WRITE  = 8'h83;
   localparam logic [7:0] REG_TORQUE  = 8'h18;
   localparam logic [7:0] REG_SPEED   = 8'h20;
   localparam logic [7:0] REG_GOAL    = 8'h1E;
   localparam logic [7:0] LEN_TORQUE  = 8'h0C;
   localparam logic [7:0] LEN_WORD    = 8'h10;
   localparam logic [7:0] DLEN_TORQUE = 8'h01;
   localparam logic [7:0] DLEN_WORD   = 8'h02;

   localparam logic [1:0] KIND_TORQUE = 2'd0;
   localparam logic [1:0] KIND_SPEED  = 2'd1;
   localparam logic [1:0] KIND_POS    = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_MOVE_SPEED = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TORQUE_ON  = 2'd1;

   localparam logic [SPEED_W-1:0] MOVE_SPEED_RST = 10'd150;

   localparam int QUEUE_DEPTH = 2;

   typedef logic [POS_W-1:0] pos_type;

   typedef struct packed {
      pos_type [3:0] pos;
   } qentry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } qstat_type;

   typedef struct packed {
      logic [SPEED_W-1:0] move_speed;
      logic               torque_on;
   } cfg_type;

endpackage

FILE: rtl/lrsf_queue.sv
module lrsf_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  lrsf_pkg::qentry_type push_data,
   input  logic                pop,
   output lrsf_pkg::qentry_type pop_data,
   output lrsf_pkg::qstat_type  qstat
);
   import lrsf_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_QW = $clog2(QUEUE_DEPTH + 1);

   qentry_type        mem_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_QW-1:0] count_ff, count_in;
   logic              do_push, do_pop;

   assign qstat.full  = (count_ff == CNT_QW'(QUEUE_DEPTH));
   assign qstat.empty = (count_ff == '0);
   assign do_push     = push && !qstat.full;
   assign do_pop      = pop && !qstat.empty;
   assign pop_data    = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

FILE: rtl/lrsf_front.sv
module lrsf_front (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  logic signed [lrsf_pkg::H_W-1:0] roll_adj,
   input  lrsf_pkg::qstat_type        qstat,
   output logic                       push,
   output lrsf_pkg::qentry_type       entry
);
   import lrsf_pkg::*;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_SEG  = 3'd1;
   localparam logic [2:0] ST_MUL  = 3'd2;
   localparam logic [2:0] ST_DIV  = 3'd3;
   localparam logic [2:0] ST_FIN  = 3'd4;
   localparam logic [2:0] ST_POS  = 3'd5;

   localparam int C_W = (Q_W > 1) ? $clog2(Q_W) : 1;

   logic [2:0]       state_ff, state_in;
   logic [H_W-1:0]   hl_ff, hl_in, hr_ff, hr_in;
   logic             leg_ff, leg_in;
   logic [H_W-1:0]   num_ff, num_in, den_ff, den_in;
   logic [Q_W-1:0]   dh_ff, dh_in, dk_ff, dk_in;
   logic [CNT_W-1:0] bh_ff, bh_in, bk_ff, bk_in;
   logic [P_W-1:0]   remh_ff, remh_in, remk_ff, remk_in, dsh_ff, dsh_in;
   logic [Q_W-1:0]   qh_ff, qh_in, qk_ff, qk_in;
   logic [C_W-1:0]   cnt_ff, cnt_in;
   logic [CNT_W-1:0] upl_ff, upl_in, dnl_ff, dnl_in, upr_ff, upr_in, dnr_ff, dnr_in;

   logic [H_W-1:0]   h_cur;
   logic [H_W-1:0]   seg_num, seg_den;
   logic [Q_W-1:0]   seg_dh, seg_dk;
   logic [CNT_W-1:0] seg_bh, seg_bk;
   logic [CNT_W-1:0] hip_res, knee_res;
   logic signed [SUM_W-1:0] v0, v1, v2, v3;
   logic signed [H_W:0] adj_w, hmax_w;

   function automatic pos_type clamp_pos(input logic signed [SUM_W-1:0] v);
      pos_type r;
      if (v < 0) begin
         r = '0;
      end else if (v > SUM_W'(POS_MAX)) begin
         r = POS_W'(POS_MAX);
      end else begin
         r = v[POS_W-1:0];
      end
      return r;
   endfunction

   assign busy = (state_ff != ST_IDLE);

   // Leg heights: positive correction shortens the right leg, negative the left.
   assign adj_w  = (H_W+1)'(roll_adj);
   assign hmax_w = signed'((H_W+1)'(HEIGHT_TAB[0]));

   // Segment lookup for the leg under work
   assign h_cur = leg_ff ? hr_ff : hl_ff;

   always_comb begin
      seg_bh  = HIP_TAB[0];
      seg_bk  = KNEE_TAB[0];
      seg_dh  = '0;
      seg_dk  = '0;
      seg_num = '0;
      seg_den = H_W'(1);
      if (h_cur >= HEIGHT_TAB[0]) begin
         seg_bh = HIP_TAB[0];
      end else if (h_cur <= HEIGHT_TAB[LAST_POINT]) begin
         seg_bh = HIP_TAB[LAST_POINT];
         seg_bk = KNEE_TAB[LAST_POINT];
      end else begin
         for (int i = LAST_POINT - 1; i >= 0; i--) begin
            if (h_cur <= HEIGHT_TAB[i] && h_cur > HEIGHT_TAB[i+1]) begin
               seg_bh  = HIP_TAB[i];
               seg_bk  = KNEE_TAB[i];
               seg_dh  = Q_W'(HIP_TAB[i+1] - HIP_TAB[i]);
               seg_dk  = Q_W'(KNEE_TAB[i+1] - KNEE_TAB[i]);
               seg_num = HEIGHT_TAB[i] - h_cur;
               seg_den = HEIGHT_TAB[i] - HEIGHT_TAB[i+1];
            end
         end
      end
   end

   assign hip_res  = bh_ff + CNT_W'(qh_ff);
   assign knee_res = bk_ff + CNT_W'(qk_ff);

   assign v0 = SUM_W'(POS_MID) + signed'(SUM_W'(upl_ff));
   assign v1 = SUM_W'(POS_MID + OFS_HIP_R) - signed'(SUM_W'(upr_ff));
   assign v2 = SUM_W'(POS_MID + OFS_KNEE_L) - signed'(SUM_W'(dnl_ff));
   assign v3 = SUM_W'(POS_MID + OFS_KNEE_R) + signed'(SUM_W'(dnr_ff));

   assign entry.pos[0] = clamp_pos(v0);
   assign entry.pos[1] = clamp_pos(v1);
   assign entry.pos[2] = clamp_pos(v2);
   assign entry.pos[3] = clamp_pos(v3);
   assign push = (state_ff == ST_POS) && !qstat.full;

   always_comb begin
      state_in = state_ff;
      hl_in = hl_ff;   hr_in = hr_ff;   leg_in = leg_ff;
      num_in = num_ff; den_in = den_ff;
      dh_in = dh_ff;   dk_in = dk_ff;   bh_in = bh_ff;   bk_in = bk_ff;
      remh_in = remh_ff; remk_in = remk_ff; dsh_in = dsh_ff;
      qh_in = qh_ff;   qk_in = qk_ff;   cnt_in = cnt_ff;
      upl_in = upl_ff; dnl_in = dnl_ff; upr_in = upr_ff; dnr_in = dnr_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               hl_in  = (adj_w < 0) ? H_W'(hmax_w + adj_w) : HEIGHT_TAB[0];
               hr_in  = (adj_w > 0) ? H_W'(hmax_w - adj_w) : HEIGHT_TAB[0];
               leg_in = 1'b0;
               state_in = ST_SEG;
            end
         end
         ST_SEG: begin
            num_in = seg_num; den_in = seg_den;
            dh_in = seg_dh;   dk_in = seg_dk;
            bh_in = seg_bh;   bk_in = seg_bk;
            state_in = ST_MUL;
         end
         ST_MUL: begin
            remh_in = P_W'(num_ff) * P_W'(dh_ff);
            remk_in = P_W'(num_ff) * P_W'(dk_ff);
            dsh_in  = P_W'(den_ff) << (Q_W - 1);
            qh_in   = '0;
            qk_in   = '0;
            cnt_in  = '0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            // one restoring quotient bit per cycle, hip and knee side by side
            if (remh_ff >= dsh_ff) begin
               remh_in = remh_ff - dsh_ff;
               qh_in   = {qh_ff[Q_W-2:0], 1'b1};
            end else begin
               qh_in   = {qh_ff[Q_W-2:0], 1'b0};
            end
            if (remk_ff >= dsh_ff) begin
               remk_in = remk_ff - dsh_ff;
               qk_in   = {qk_ff[Q_W-2:0], 1'b1};
            end else begin
               qk_in   = {qk_ff[Q_W-2:0], 1'b0};
            end
            dsh_in = dsh_ff >> 1;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == C_W'(Q_W - 1)) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            if (!leg_ff) begin
               upl_in = hip_res;
               dnl_in = knee_res;
               leg_in = 1'b1;
               state_in = ST_SEG;
            end else begin
               upr_in = hip_res;
               dnr_in = knee_res;
               state_in = ST_POS;
            end
         end
         ST_POS: begin
            if (!qstat.full) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      hl_ff <= hl_in;   hr_ff <= hr_in;   leg_ff <= leg_in;
      num_ff <= num_in; den_ff <= den_in;
      dh_ff <= dh_in;   dk_ff <= dk_in;   bh_ff <= bh_in;   bk_ff <= bk_in;
      remh_ff <= remh_in; remk_ff <= remk_in; dsh_ff <= dsh_in;
      qh_ff <= qh_in;   qk_ff <= qk_in;   cnt_ff <= cnt_in;
      upl_ff <= upl_in; dnl_ff <= dnl_in; upr_ff <= upr_in; dnr_ff <= dnr_in;
   end

endmodule

FILE: rtl/lrsf_back.sv
module lrsf_back (
   input  logic                 clock,
   input  logic                 reset,
   input  lrsf_pkg::cfg_type    cfg,
   input  lrsf_pkg::qstat_type  qstat,
   input  lrsf_pkg::qentry_type entry,
   output logic                 pop,
   output logic                 rsp_valid,
   output logic [lrsf_pkg::BYTE_W-1:0] rsp_frame_byte,
   output logic [1:0]           rsp_frame_kind,
   output logic                 rsp_frame_end,
   output logic                 rsp_run_end
);
   import lrsf_pkg::*;

   localparam int OFF_W = 5;
   localparam logic [OFF_W-1:0] OFF_ID     = 5'd2;
   localparam logic [OFF_W-1:0] OFF_LEN    = 5'd3;
   localparam logic [OFF_W-1:0] OFF_INSTR  = 5'd4;
   localparam logic [OFF_W-1:0] OFF_REG    = 5'd5;
   localparam logic [OFF_W-1:0] OFF_DLEN   = 5'd6;
   localparam logic [OFF_W-1:0] CK_TORQUE  = 5'd15;
   localparam logic [OFF_W-1:0] CK_WORD    = 5'd19;

   localparam logic [1:0] F_ID = 2'd0;
   localparam logic [1:0] F_LO = 2'd1;
   localparam logic [1:0] F_HI = 2'd2;

   logic              active_ff, active_in;
   logic [OFF_W-1:0]  off_ff, off_in;
   logic [1:0]        kind_ff, kind_in;
   logic [1:0]        field_ff, field_in;
   logic [1:0]        slot_ff, slot_in;
   logic [BYTE_W-1:0] sum_ff, sum_in;
   qentry_type        pos_ff, pos_in;

   logic              is_ck, run_last, load;
   logic [1:0]        last_field;
   logic [BYTE_W-1:0] byte_cur, data_byte;
   pos_type           pos_cur;

   assign is_ck      = (off_ff == ((kind_ff == KIND_TORQUE) ? CK_TORQUE : CK_WORD));
   assign run_last   = active_ff && is_ck && (kind_ff == KIND_POS);
   assign load       = (!active_ff || run_last) && !qstat.empty;
   assign pop        = load;
   assign last_field = (kind_ff == KIND_TORQUE) ? F_LO : F_HI;
   assign pos_cur    = pos_ff.pos[slot_ff];

   always_comb begin
      unique case (field_ff)
         F_ID: data_byte = BYTE_W'(slot_ff);
         F_LO: begin
            unique case (kind_ff)
               KIND_TORQUE: data_byte = BYTE_W'(cfg.torque_on);
               KIND_SPEED:  data_byte = cfg.move_speed[7:0];
               default:     data_byte = pos_cur[7:0];
            endcase
         end
         default: begin
            data_byte = (kind_ff == KIND_SPEED) ? BYTE_W'(cfg.move_speed[SPEED_W-1:8])
                                                : BYTE_W'(pos_cur[POS_W-1:8]);
         end
      endcase
   end

   always_comb begin
      if (is_ck) begin
         byte_cur = ~sum_ff;
      end else begin
         unique case (off_ff)
            OFF_ID:    byte_cur = BCAST_ID;
            OFF_LEN:   byte_cur = (kind_ff == KIND_TORQUE) ? LEN_TORQUE : LEN_WORD;
            OFF_INSTR: byte_cur = SYNC_WRITE;
            OFF_REG: begin
               unique case (kind_ff)
                  KIND_TORQUE: byte_cur = REG_TORQUE;
                  KIND_SPEED:  byte_cur = REG_SPEED;
                  default:     byte_cur = REG_GOAL;
               endcase
            end
            OFF_DLEN:  byte_cur = (kind_ff == KIND_TORQUE) ? DLEN_TORQUE : DLEN_WORD;
            default:   byte_cur = (off_ff < OFF_ID) ? HDR_BYTE : data_byte;
         endcase
      end
   end

   always_comb begin
      active_in = active_ff;
      off_in    = off_ff;
      kind_in   = kind_ff;
      field_in  = field_ff;
      slot_in   = slot_ff;
      sum_in    = sum_ff;
      pos_in    = pos_ff;
      if (active_ff) begin
         if (is_ck) begin
            off_in   = '0;
            field_in = F_ID;
            slot_in  = '0;
            sum_in   = '0;
            kind_in  = (kind_ff == KIND_POS) ? KIND_TORQUE : kind_ff + 1'b1;
         end else begin
            off_in = off_ff + 1'b1;
            if (off_ff >= OFF_ID) begin
               sum_in = sum_ff + byte_cur;
            end
            if (off_ff > OFF_DLEN) begin
               if (field_ff == last_field) begin
                  field_in = F_ID;
                  slot_in  = slot_ff + 1'b1;
               end else begin
                  field_in = field_ff + 1'b1;
               end
            end
         end
      end
      if (run_last) begin
         active_in = 1'b0;
      end
      if (load) begin
         active_in = 1'b1;
         pos_in    = entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         off_ff    <= '0;
         kind_ff   <= KIND_TORQUE;
         field_ff  <= F_ID;
         slot_ff   <= '0;
         sum_ff    <= '0;
         rsp_valid <= 1'b0;
      end else begin
         active_ff <= active_in;
         off_ff    <= off_in;
         kind_ff   <= kind_in;
         field_ff  <= field_in;
         slot_ff   <= slot_in;
         sum_ff    <= sum_in;
         rsp_valid <= active_ff;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff         <= pos_in;
      rsp_frame_byte <= byte_cur;
      rsp_frame_kind <= kind_ff;
      rsp_frame_end  <= is_ck;
      rsp_run_end    <= run_last;
   end

endmodule

FILE: rtl/leg_roll_servo_sync_framer.sv
// Roll-compensating leg servo framer.
// Input: a transaction is taken on a rising edge with start high and busy low;
//   req_roll_adj is a signed roll correction in 1/256 mm.
// Output: each transaction yields a 56-byte run (torque 16, speed 20, position
//   20 bytes), one byte per cycle on rsp_frame_byte, qualified by rsp_valid.
//   rsp_frame_end marks each checksum byte, rsp_run_end the last byte of a run.
//   The receiver cannot stall: bytes leave at a fixed one per cycle.
// The front end maps both legs in turn through the height table; each leg
//   spends one lookup, one multiply and a 6-bit restoring divide, then
//   positions are clamped.
// The byte serializer sets the pace; busy stays high until the front end has
//   queued its item. A 2-entry queue lets the front end finish the next item
//   while the current run is still going out, so back-to-back runs leave
//   without a gap. Config: csr_index 0 = move_speed, 1 = torque_on; always
//   ready. The user must write them only while the block is idle; the block
//   does not enforce it. Reset loads 150 and 1, empties the queue.
module leg_roll_servo_sync_framer (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  logic signed [lrsf_pkg::H_W-1:0]       req_roll_adj,
   output logic                                  rsp_valid,
   output logic [lrsf_pkg::BYTE_W-1:0]           rsp_frame_byte,
   output logic [1:0]                            rsp_frame_kind,
   output logic                                  rsp_frame_end,
   output logic                                  rsp_run_end,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [lrsf_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [lrsf_pkg::SPEED_W-1:0]          csr_wdata
);
   import lrsf_pkg::*;

   cfg_type    cfg_ff, cfg_in;
   qstat_type  qstat;
   qentry_type push_data, pop_data;
   logic       push, pop;

   // Config registers
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_MOVE_SPEED: cfg_in.move_speed = csr_wdata;
            CSR_TORQUE_ON:  cfg_in.torque_on  = csr_wdata[0];
            default:        cfg_in = cfg_ff;   // unmapped index, dropped
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.move_speed <= MOVE_SPEED_RST;
         cfg_ff.torque_on  <= 1'b1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Front end: leg heights, table interpolation, clamped positions
   lrsf_front u_front (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .roll_adj (req_roll_adj),
      .qstat    (qstat),
      .push     (push),
      .entry    (push_data)
   );

   // Position queue between front end and serializer
   lrsf_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .pop_data  (pop_data),
      .qstat     (qstat)
   );

   // Back end: frame serializer with running checksum
   lrsf_back u_back (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg_ff),
      .qstat          (qstat),
      .entry          (pop_data),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_frame_byte (rsp_frame_byte),
      .rsp_frame_kind (rsp_frame_kind),
      .rsp_frame_end  (rsp_frame_end),
      .rsp_run_end    (rsp_run_end)
   );

   // Run end only on the position checksum
   a_run_end_on_pos_ck: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_run_end |-> rsp_frame_end && rsp_frame_kind == KIND_POS)
      else $error("run end outside the position checksum");

   // A run always opens with a torque frame header byte
   a_run_opens_with_header: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> rsp_frame_byte == HDR_BYTE && rsp_frame_kind == KIND_TORQUE)
      else $error("run does not open with a torque header");

   // Frames follow each other without a gap inside a run
   a_frame_order: assert property (@(posedge clock) disable iff (reset)
      $past(rsp_valid) && $past(rsp_frame_end) && !$past(rsp_run_end)
      |-> rsp_valid && rsp_frame_kind == 2'($past(rsp_frame_kind) + 2'd1))
      else $error("frame sequence broken inside a run");

   // A popped entry puts its torque header on the ports, through the frame state and then the output registers
   a_queue_busy: assert property (@(posedge clock) disable iff (reset)
      pop |-> ##2 rsp_valid && rsp_frame_kind == KIND_TORQUE && rsp_frame_byte == HDR_BYTE)
      else $error("popped entry did not start a run");

endmodule
